>>> rtl/slsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfr_pkg
// Shared types and constants for the sync/length/sum frame receiver.
// ----------------------------------------------------------------------------
package slsfr_pkg;

   localparam logic [7:0]  SYNC0          = 8'h4E;
   localparam logic [7:0]  SYNC1          = 8'h57;
   localparam logic [15:0] MIN_LEN        = 16'd9;
   localparam logic [15:0] GAP_LIMIT_RST  = 16'd50;
   localparam logic [16:0] FUNC_POS       = 17'd8;
   localparam logic [16:0] PAYLOAD_FIRST  = 17'd11;
   localparam logic [17:0] PAYLOAD_TAIL   = 18'd4;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_GOOD      = 2'd1,
      KIND_SUM_ERR   = 2'd2,
      KIND_HDR_ERR   = 2'd3
   } kind_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  function_code;
      logic [15:0] frame_length;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/sync_length_sum_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit
// Path: a beat taken on req_ is held in the input register and decoded by the
// parser; a result is pushed to the buffer whose output register drives rsp_.
// Throughput: one beat (byte or tick) per cycle while not stalled; the parse
// is a single pass between the input register and a two-entry result buffer.
// Reset: synchronous; clears frame state, idle count and buffers, and sets
// the gap limit to 50 ticks.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_function_code,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_computed_sum,
   output logic [15:0] rsp_received_sum,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_gap_limit_ticks
);
   import slsfr_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    advance;
   logic    room;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;
   logic    req_take;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the beat while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.opcode  <= req_opcode;
         in_ff.rx_byte <= req_rx_byte;
      end
   end

   slsfr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg_we        (csr_valid && csr_ready),
      .cfg_gap_limit (csr_gap_limit_ticks),
      .item_advance  (advance),
      .item          (in_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   slsfr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_function_code = out_data.function_code;
   assign rsp_frame_length  = out_data.frame_length;
   assign rsp_computed_sum  = out_data.computed_sum;
   assign rsp_received_sum  = out_data.received_sum;
   assign rsp_last          = out_data.last;

endmodule

>>> rtl/slsfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfr_parser
// Frame state, gap timer and the per-beat decode of one registered item.
// ----------------------------------------------------------------------------
module slsfr_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_we,
   input  logic [15:0]       cfg_gap_limit,
   input  logic              item_advance,
   input  slsfr_pkg::req_type item,
   output logic              res_valid,
   output slsfr_pkg::rsp_type res
);
   import slsfr_pkg::*;

   logic [15:0] gap_limit_ff;
   logic [16:0] position_ff, position_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] sum_ff, sum_in;
   logic        sync_ok_ff, sync_ok_in;
   logic [7:0]  cs_high_ff, cs_high_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] sum_add;
   logic [15:0] len_full;
   logic [15:0] idle_inc;
   logic [15:0] rx_sum;

   assign sum_add  = sum_ff + {8'h00, item.rx_byte};
   assign len_full = {length_ff[15:8], item.rx_byte};
   assign idle_inc = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
   assign rx_sum   = {cs_high_ff, item.rx_byte};

   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      sync_ok_in  = sync_ok_ff;
      cs_high_in  = cs_high_ff;
      func_in     = func_ff;
      idle_in     = idle_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (item.opcode == OP_TICK) begin
         idle_in = idle_inc;
         if (idle_inc > gap_limit_ff) begin
            idle_in     = '0;
            position_in = '0;
            length_in   = '0;
            sum_in      = '0;
            sync_ok_in  = 1'b0;
            cs_high_in  = '0;
            func_in     = '0;
         end
      end else begin
         idle_in = '0;
         if (position_ff == 17'd0) begin
            sync_ok_in  = (item.rx_byte == SYNC0);
            sum_in      = {8'h00, item.rx_byte};
            position_in = 17'd1;
         end else if (position_ff == 17'd1) begin
            sync_ok_in  = sync_ok_ff && (item.rx_byte == SYNC1);
            sum_in      = sum_add;
            position_in = 17'd2;
         end else if (position_ff == 17'd2) begin
            if (!sync_ok_ff) begin
               position_in = '0;
               length_in   = '0;
               sum_in      = '0;
               sync_ok_in  = 1'b0;
               cs_high_in  = '0;
               func_in     = '0;
               res_valid   = 1'b1;
               res.kind    = KIND_HDR_ERR;
               res.last    = 1'b1;
            end else begin
               length_in   = {item.rx_byte, 8'h00};
               sum_in      = sum_add;
               position_in = 17'd3;
            end
         end else if (position_ff == 17'd3) begin
            if (len_full < MIN_LEN) begin
               position_in      = '0;
               length_in        = '0;
               sum_in           = '0;
               sync_ok_in       = 1'b0;
               cs_high_in       = '0;
               func_in          = '0;
               res_valid        = 1'b1;
               res.kind         = KIND_HDR_ERR;
               res.frame_length = len_full;
               res.last         = 1'b1;
            end else begin
               length_in   = len_full;
               sum_in      = sum_add;
               position_in = 17'd4;
            end
         end else if (position_ff < {1'b0, length_ff}) begin
            sum_in      = sum_add;
            position_in = position_ff + 17'd1;
            if (position_ff == FUNC_POS) begin
               func_in = item.rx_byte;
            end
            if (position_ff >= PAYLOAD_FIRST &&
                ({1'b0, position_ff} + PAYLOAD_TAIL) <= {2'b00, length_ff}) begin
               res_valid         = 1'b1;
               res.kind          = KIND_PAYLOAD;
               res.payload_byte  = item.rx_byte;
               res.function_code = func_ff;
               res.frame_length  = length_ff;
            end
         end else if (position_ff == {1'b0, length_ff}) begin
            cs_high_in  = item.rx_byte;
            position_in = position_ff + 17'd1;
         end else begin
            position_in       = '0;
            length_in         = '0;
            sum_in            = '0;
            sync_ok_in        = 1'b0;
            cs_high_in        = '0;
            func_in           = '0;
            res_valid         = 1'b1;
            res.kind          = (sum_ff == rx_sum) ? KIND_GOOD : KIND_SUM_ERR;
            res.function_code = func_ff;
            res.frame_length  = length_ff;
            res.computed_sum  = sum_ff;
            res.received_sum  = rx_sum;
            res.last          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_LIMIT_RST;
         position_ff  <= '0;
         length_ff    <= '0;
         sum_ff       <= '0;
         sync_ok_ff   <= 1'b0;
         cs_high_ff   <= '0;
         func_ff      <= '0;
         idle_ff      <= '0;
      end else begin
         if (cfg_we) begin
            gap_limit_ff <= cfg_gap_limit;
         end
         if (item_advance) begin
            position_ff <= position_in;
            length_ff   <= length_in;
            sum_ff      <= sum_in;
            sync_ok_ff  <= sync_ok_in;
            cs_high_ff  <= cs_high_in;
            func_ff     <= func_in;
            idle_ff     <= idle_in;
         end
      end
   end

endmodule

>>> rtl/slsfr_rsp_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsfr_rsp_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module slsfr_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slsfr_pkg::rsp_type push_data,
   output logic              room,
   output logic              out_valid,
   input  logic              out_stall,
   output slsfr_pkg::rsp_type out_data
);
   import slsfr_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff && !out_stall;
   assign room      = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
